// ===== hdl/acr_pkg.sv =====
package acr_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int DATA_W = 64;
    localparam int ADDR_W = 5;

    // register index, byte address 8*index
    localparam logic [1:0] REG_LOCAL_IP    = 2'd0;
    localparam logic [1:0] REG_SUBNET_MASK = 2'd1;
    localparam logic [1:0] REG_GATEWAY_IP  = 2'd2;
    localparam logic [1:0] REG_LOCAL_MAC   = 2'd3;

    localparam logic [15:0] ARP_HTYPE_ETH  = 16'h0001;
    localparam logic [15:0] ARP_PTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  ARP_HLEN       = 8'h06;
    localparam logic [7:0]  ARP_PLEN       = 8'h04;
    localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
    localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

    localparam logic [1:0] OUT_OP_NONE    = 2'd0;
    localparam logic [1:0] OUT_OP_REQUEST = 2'd1;
    localparam logic [1:0] OUT_OP_REPLY   = 2'd2;

    localparam logic [2:0] ACT_NOTHING  = 3'd0;
    localparam logic [2:0] ACT_REPLY    = 3'd1;
    localparam logic [2:0] ACT_REQUEST  = 3'd2;
    localparam logic [2:0] ACT_RESOLVED = 3'd3;
    localparam logic [2:0] ACT_BAD_PKT  = 3'd4;
    localparam logic [2:0] ACT_BAD_DST  = 3'd5;

    localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};
    localparam logic [IP_W-1:0]  BCAST_IP  = {IP_W{1'b1}};

    typedef struct packed {
        logic        func;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_len;
        logic [7:0]  proto_len;
        logic [15:0] arp_opcode;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
        logic [31:0] dest_ip;
    } acr_req_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [47:0] frame_dst_mac;
        logic [1:0]  out_opcode;
        logic [31:0] out_sender_ip;
        logic [47:0] out_target_mac;
        logic [31:0] out_target_ip;
        logic        table_full;
    } acr_rsp_t;

    // search token walking down the cell chain
    typedef struct packed {
        logic             vld;
        logic [IP_W-1:0]  key;
        logic             upd;
        logic [MAC_W-1:0] mac;
        logic             hit;
        logic [MAC_W-1:0] hit_mac;
        logic             free;
        logic [IDX_W-1:0] free_idx;
    } acr_tok_t;

    typedef struct packed {
        logic             en;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } acr_wr_t;

endpackage

// ===== hdl/acr_cell.sv =====
module acr_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [acr_pkg::IDX_W-1:0]   idx,
    input  acr_pkg::acr_tok_t           tok_in,
    output acr_pkg::acr_tok_t           tok_out,
    input  acr_pkg::acr_wr_t            wr
);
    import acr_pkg::*;

    logic             valid_reg, valid_next;
    logic [IP_W-1:0]  ip_reg, ip_next;
    logic [MAC_W-1:0] mac_reg, mac_next;
    acr_tok_t         tok_reg, tok_next;
    logic             match;

    assign match = tok_in.vld && valid_reg && (ip_reg == tok_in.key);

    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        ip_next    = ip_reg;
        mac_next   = mac_reg;
        if (match && !tok_in.hit)
        begin
            tok_next.hit     = 1'b1;
            tok_next.hit_mac = mac_reg;
            if (tok_in.upd)
            begin
                mac_next = tok_in.mac;
            end
        end
        if (tok_in.vld && !tok_in.free && !valid_reg)
        begin
            tok_next.free     = 1'b1;
            tok_next.free_idx = idx;
        end
        if (wr.en)
        begin
            valid_next = 1'b1;
            ip_next    = wr.ip;
            mac_next   = wr.mac;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ip_reg  <= ip_next;
        mac_reg <= mac_next;
    end

    assign tok_out = tok_reg;

endmodule

// ===== hdl/arp_cache_responder.sv =====
// A searched word passes inj_reg, one register per cell and fin_reg before the
// result register; other words go from intake to ST_FIN and then to the result.
// Throughput: one word at a time; the search token walks the cell chain one
// entry per cycle, so the next word is taken after the result is registered.
// Reset: async, active low; clears entry valid bits, config and FSM registers.
module arp_cache_responder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [acr_pkg::ADDR_W-1:0]  paddr,
    input  logic [acr_pkg::DATA_W-1:0]  pwdata,
    output logic [acr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  acr_pkg::acr_req_t           req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output acr_pkg::acr_rsp_t           rsp
);
    import acr_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_FIN    = 2'd2;

    localparam logic [2:0] CLS_BAD_PKT = 3'd0;
    localparam logic [2:0] CLS_NOADDR  = 3'd1;
    localparam logic [2:0] CLS_ARP     = 3'd2;
    localparam logic [2:0] CLS_BCAST   = 3'd3;
    localparam logic [2:0] CLS_BAD_DST = 3'd4;
    localparam logic [2:0] CLS_RESOLVE = 3'd5;

    logic [IP_W-1:0]  local_ip_reg, subnet_mask_reg, gateway_ip_reg;
    logic [MAC_W-1:0] local_mac_reg;
    logic             cfg_wr;
    logic [1:0]       cfg_idx;

    logic [1:0]       state_reg, state_next;
    logic [2:0]       cls_reg, cls_next;
    logic [IP_W-1:0]  key_reg, key_next;
    logic [MAC_W-1:0] sha_reg, sha_next;
    logic [IP_W-1:0]  tpa_reg, tpa_next;
    logic             reply_reg, reply_next;
    logic             tgt_us_reg, tgt_us_next;
    acr_tok_t         inj_reg, inj_next;
    acr_tok_t         fin_reg, fin_next;
    logic             rsp_valid_reg, rsp_valid_next;
    acr_rsp_t         rsp_reg, rsp_next, result;

    logic             accept, pkt_ok, off_subnet, load, learn;
    logic [IP_W-1:0]  hop;
    acr_tok_t         chain [TABLE_ENTRIES+1];
    acr_wr_t          wr_cell [TABLE_ENTRIES];

    // configuration
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg    <= '0;
            subnet_mask_reg <= '0;
            gateway_ip_reg  <= '0;
            local_mac_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_LOCAL_IP:    local_ip_reg    <= pwdata[IP_W-1:0];
                REG_SUBNET_MASK: subnet_mask_reg <= pwdata[IP_W-1:0];
                REG_GATEWAY_IP:  gateway_ip_reg  <= pwdata[IP_W-1:0];
                REG_LOCAL_MAC:   local_mac_reg   <= pwdata[MAC_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_LOCAL_IP:    prdata = DATA_W'(local_ip_reg);
            REG_SUBNET_MASK: prdata = DATA_W'(subnet_mask_reg);
            REG_GATEWAY_IP:  prdata = DATA_W'(gateway_ip_reg);
            REG_LOCAL_MAC:   prdata = DATA_W'(local_mac_reg);
            default:         prdata = '0;
        endcase
    end

    // intake
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;

    assign pkt_ok = (req.hw_type == ARP_HTYPE_ETH) && (req.proto_type == ARP_PTYPE_IPV4) &&
                    (req.hw_len == ARP_HLEN) && (req.proto_len == ARP_PLEN) &&
                    ((req.arp_opcode == ARP_OP_REQUEST) || (req.arp_opcode == ARP_OP_REPLY)) &&
                    (req.sender_mac != BCAST_MAC);
    assign off_subnet = (req.dest_ip & subnet_mask_reg) != (local_ip_reg & subnet_mask_reg);
    assign hop        = off_subnet ? gateway_ip_reg : req.dest_ip;

    // cell chain
    assign chain[0] = inj_reg;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            always_comb
            begin
                wr_cell[gi].en  = learn && fin_reg.free && load &&
                                  (fin_reg.free_idx == IDX_W'(gi));
                wr_cell[gi].ip  = key_reg;
                wr_cell[gi].mac = sha_reg;
            end

            acr_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .idx     (IDX_W'(gi)),
                .tok_in  (chain[gi]),
                .tok_out (chain[gi+1]),
                .wr      (wr_cell[gi])
            );
        end
    endgenerate

    // result
    assign learn = (cls_reg == CLS_ARP) && tgt_us_reg && !fin_reg.hit;
    assign load  = (state_reg == ST_FIN) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        result = '0;
        unique case (cls_reg)
            CLS_BAD_PKT: result.action = ACT_BAD_PKT;
            CLS_NOADDR:  result.action = ACT_NOTHING;
            CLS_ARP:
            begin
                result.table_full = learn && !fin_reg.free;
                if (reply_reg)
                begin
                    result.action         = ACT_REPLY;
                    result.frame_dst_mac  = sha_reg;
                    result.out_opcode     = OUT_OP_REPLY;
                    result.out_sender_ip  = tpa_reg;
                    result.out_target_mac = sha_reg;
                    result.out_target_ip  = key_reg;
                end
            end
            CLS_BCAST:
            begin
                result.action        = ACT_RESOLVED;
                result.frame_dst_mac = BCAST_MAC;
            end
            CLS_BAD_DST: result.action = ACT_BAD_DST;
            CLS_RESOLVE:
            begin
                if (fin_reg.hit)
                begin
                    result.action        = ACT_RESOLVED;
                    result.frame_dst_mac = fin_reg.hit_mac;
                end
                else
                begin
                    result.action         = ACT_REQUEST;
                    result.frame_dst_mac  = BCAST_MAC;
                    result.out_opcode     = OUT_OP_REQUEST;
                    result.out_sender_ip  = local_ip_reg;
                    result.out_target_mac = BCAST_MAC;
                    result.out_target_ip  = key_reg;
                end
            end
            default: result = '0;
        endcase
    end

    // control
    always_comb
    begin
        state_next     = state_reg;
        cls_next       = cls_reg;
        key_next       = key_reg;
        sha_next       = sha_reg;
        tpa_next       = tpa_reg;
        reply_next     = reply_reg;
        tgt_us_next    = tgt_us_reg;
        inj_next       = '0;
        fin_next       = fin_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fin_next    = '0;
                    sha_next    = req.sender_mac;
                    tpa_next    = req.target_ip;
                    tgt_us_next = (req.target_ip == local_ip_reg);
                    reply_next  = (req.target_ip == local_ip_reg) &&
                                  (req.arp_opcode == ARP_OP_REQUEST);
                    state_next  = ST_FIN;
                    if (!req.func)
                    begin
                        key_next = req.sender_ip;
                        priority if (!pkt_ok)
                            cls_next = CLS_BAD_PKT;
                        else if (local_ip_reg == '0)
                            cls_next = CLS_NOADDR;
                        else
                        begin
                            cls_next   = CLS_ARP;
                            state_next = ST_SEARCH;
                            inj_next.vld = 1'b1;
                            inj_next.key = req.sender_ip;
                            inj_next.upd = 1'b1;
                            inj_next.mac = req.sender_mac;
                        end
                    end
                    else
                    begin
                        key_next = hop;
                        priority if (req.dest_ip == BCAST_IP)
                            cls_next = CLS_BCAST;
                        else if (req.dest_ip == '0)
                            cls_next = CLS_BAD_DST;
                        else if (off_subnet && (gateway_ip_reg == '0))
                            cls_next = CLS_BAD_DST;
                        else
                        begin
                            cls_next   = CLS_RESOLVE;
                            state_next = ST_SEARCH;
                            inj_next.vld = 1'b1;
                            inj_next.key = hop;
                        end
                    end
                end
            end
            ST_SEARCH:
            begin
                if (chain[TABLE_ENTRIES].vld)
                begin
                    fin_next   = chain[TABLE_ENTRIES];
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (load)
                begin
                    rsp_next       = result;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            inj_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            inj_reg       <= inj_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg    <= cls_next;
        key_reg    <= key_next;
        sha_reg    <= sha_next;
        tpa_reg    <= tpa_next;
        reply_reg  <= reply_next;
        tgt_us_reg <= tgt_us_next;
        fin_reg    <= fin_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== bench/arp_cache_responder_tb.sv =====
module arp_cache_responder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import acr_pkg::*;

    localparam int POOL_SIZE = 24;
    localparam int LONG_HOLD = 300;

    class arp_scoreboard;
        logic [IP_W-1:0]  own_ip;
        logic [IP_W-1:0]  netmask;
        logic [IP_W-1:0]  router_ip;
        logic [MAC_W-1:0] own_mac;
        logic             cache_valid [TABLE_ENTRIES];
        logic [IP_W-1:0]  cache_ip    [TABLE_ENTRIES];
        logic [MAC_W-1:0] cache_mac   [TABLE_ENTRIES];
        acr_rsp_t         predicted_rsp [$];
        int               errors;

        function new();
            own_ip = '0;
            netmask = '0;
            router_ip = '0;
            own_mac = '0;
            errors = 0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                cache_valid[i] = 1'b0;
                cache_ip[i] = '0;
                cache_mac[i] = '0;
            end
        endfunction

        function int pending();
            return predicted_rsp.size();
        endfunction

        function void set_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_LOCAL_IP:    own_ip = value[IP_W-1:0];
                REG_SUBNET_MASK: netmask = value[IP_W-1:0];
                REG_GATEWAY_IP:  router_ip = value[IP_W-1:0];
                REG_LOCAL_MAC:   own_mac = value[MAC_W-1:0];
                default: ;
            endcase
        endfunction

        function int find_entry(logic [IP_W-1:0] ip);
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (cache_valid[i] && cache_ip[i] == ip)
                    return i;
            return -1;
        endfunction

        function bit store_entry(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (!cache_valid[i])
                begin
                    cache_valid[i] = 1'b1;
                    cache_ip[i] = ip;
                    cache_mac[i] = mac;
                    return 1'b1;
                end
            return 1'b0;
        endfunction

        function void note_word(acr_req_t w);
            acr_rsp_t        r;
            int              hit;
            logic [IP_W-1:0] hop;
            logic            well_formed;
            r = '0;
            if (w.func == 1'b0)
            begin
                well_formed = w.hw_type == ARP_HTYPE_ETH && w.proto_type == ARP_PTYPE_IPV4 &&
                              w.hw_len == ARP_HLEN && w.proto_len == ARP_PLEN &&
                              (w.arp_opcode == ARP_OP_REQUEST ||
                               w.arp_opcode == ARP_OP_REPLY) &&
                              w.sender_mac != BCAST_MAC;
                if (!well_formed)
                    r.action = ACT_BAD_PKT;
                else if (own_ip != '0)
                begin
                    hit = find_entry(w.sender_ip);
                    if (hit >= 0)
                        cache_mac[hit] = w.sender_mac;
                    if (w.target_ip == own_ip)
                    begin
                        if (hit < 0 && !store_entry(w.sender_ip, w.sender_mac))
                            r.table_full = 1'b1;
                        if (w.arp_opcode == ARP_OP_REQUEST)
                        begin
                            r.action = ACT_REPLY;
                            r.frame_dst_mac = w.sender_mac;
                            r.out_opcode = OUT_OP_REPLY;
                            r.out_sender_ip = w.target_ip;
                            r.out_target_mac = w.sender_mac;
                            r.out_target_ip = w.sender_ip;
                        end
                    end
                end
            end
            else if (w.dest_ip == BCAST_IP)
            begin
                r.action = ACT_RESOLVED;
                r.frame_dst_mac = BCAST_MAC;
            end
            else if (w.dest_ip == '0)
                r.action = ACT_BAD_DST;
            else
            begin
                hop = w.dest_ip;
                if ((w.dest_ip & netmask) != (own_ip & netmask))
                    hop = router_ip;
                if (hop == '0)
                    r.action = ACT_BAD_DST;
                else
                begin
                    hit = find_entry(hop);
                    if (hit >= 0)
                    begin
                        r.action = ACT_RESOLVED;
                        r.frame_dst_mac = cache_mac[hit];
                    end
                    else
                    begin
                        r.action = ACT_REQUEST;
                        r.frame_dst_mac = BCAST_MAC;
                        r.out_opcode = OUT_OP_REQUEST;
                        r.out_sender_ip = own_ip;
                        r.out_target_mac = BCAST_MAC;
                        r.out_target_ip = hop;
                    end
                end
            end
            predicted_rsp.insert(predicted_rsp.size(), r);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
            errors++;
        endtask

        task field_check(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch(name, got, want);
        endtask

        task check_word(acr_rsp_t got);
            acr_rsp_t want;
            if (predicted_rsp.size() == 0)
            begin
                report_mismatch("unexpected result word", 64'(got.action), '0);
                return;
            end
            want = predicted_rsp.pop_front();
            field_check("action", 64'(got.action), 64'(want.action));
            field_check("frame_dst_mac", 64'(got.frame_dst_mac), 64'(want.frame_dst_mac));
            field_check("out_opcode", 64'(got.out_opcode), 64'(want.out_opcode));
            field_check("out_sender_ip", 64'(got.out_sender_ip), 64'(want.out_sender_ip));
            field_check("out_target_mac", 64'(got.out_target_mac),
                        64'(want.out_target_mac));
            field_check("out_target_ip", 64'(got.out_target_ip), 64'(want.out_target_ip));
            field_check("table_full", 64'(got.table_full), 64'(want.table_full));
        endtask

        task flush_check();
            if (predicted_rsp.size() != 0)
                report_mismatch("results never arrived", 64'(predicted_rsp.size()), '0);
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              req_valid = 1'b0;
    logic              req_stall;
    acr_req_t          req = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    acr_rsp_t          rsp;

    arp_scoreboard     sb;
    bit                idle_on = 1'b1;
    int                rsp_hold = 0;
    logic [IP_W-1:0]   ip_pool [POOL_SIZE];

    arp_cache_responder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_word(rsp);
    end

    // result side back-pressure
    initial
    begin
        int n;
        forever
        begin
            if (rsp_hold > 0)
                n = rsp_hold;
            else
                n = idle_on ? $urandom_range(0, 8) : 0;
            rsp_hold = 0;
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            do @(posedge clk); while (!(rst_n && rsp_valid));
        end
    end

    function automatic logic [MAC_W-1:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    function automatic acr_req_t noise_word();
        acr_req_t w;
        w.func = 1'($urandom);
        w.hw_type = 16'($urandom);
        w.proto_type = 16'($urandom);
        w.hw_len = 8'($urandom);
        w.proto_len = 8'($urandom);
        w.arp_opcode = 16'($urandom);
        w.sender_mac = rand48();
        w.sender_ip = $urandom;
        w.target_ip = $urandom;
        w.dest_ip = $urandom;
        return w;
    endfunction

    function automatic acr_req_t arp_word(logic [15:0] op, logic [MAC_W-1:0] smac,
                                          logic [IP_W-1:0] sip, logic [IP_W-1:0] tip);
        acr_req_t w;
        w = noise_word();
        w.func = 1'b0;
        w.hw_type = ARP_HTYPE_ETH;
        w.proto_type = ARP_PTYPE_IPV4;
        w.hw_len = ARP_HLEN;
        w.proto_len = ARP_PLEN;
        w.arp_opcode = op;
        w.sender_mac = smac;
        w.sender_ip = sip;
        w.target_ip = tip;
        return w;
    endfunction

    function automatic acr_req_t resolve_word(logic [IP_W-1:0] dst);
        acr_req_t w;
        w = noise_word();
        w.func = 1'b1;
        w.dest_ip = dst;
        return w;
    endfunction

    function automatic acr_req_t random_word();
        acr_req_t        w;
        int              pick;
        logic [IP_W-1:0] tip;
        logic [IP_W-1:0] sip;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return noise_word();
        if (pick < 62)
        begin
            sip = ($urandom_range(0, 3) != 0) ? ip_pool[$urandom_range(0, POOL_SIZE - 1)]
                                              : $urandom;
            case ($urandom_range(0, 4))
                0, 1, 2: tip = sb.own_ip;
                3:       tip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
                default: tip = $urandom;
            endcase
            w = arp_word(16'($urandom_range(1, 2)), rand48(), sip, tip);
            // broken packets: one header field off
            if (pick >= 54)
                case ($urandom_range(0, 5))
                    0: w.hw_type ^= 16'($urandom_range(1, 65535));
                    1: w.proto_type ^= 16'($urandom_range(1, 65535));
                    2: w.hw_len ^= 8'($urandom_range(1, 255));
                    3: w.proto_len ^= 8'($urandom_range(1, 255));
                    4: w.arp_opcode = $urandom_range(0, 1) ? 16'd0
                                                           : 16'($urandom_range(3, 65535));
                    default: w.sender_mac = BCAST_MAC;
                endcase
            return w;
        end
        case ($urandom_range(0, 9))
            0:       return resolve_word(BCAST_IP);
            1:       return resolve_word('0);
            2:       return resolve_word(sb.router_ip);
            3:       return resolve_word($urandom);
            4:       return resolve_word(sb.own_ip);
            default: return resolve_word(ip_pool[$urandom_range(0, POOL_SIZE - 1)]);
        endcase
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [IP_W-1:0] ip, input logic [IP_W-1:0] mask,
                                 input logic [IP_W-1:0] gw, input logic [MAC_W-1:0] mac);
        reg_write(REG_LOCAL_IP, {$urandom, ip});
        reg_write(REG_SUBNET_MASK, {$urandom, mask});
        reg_write(REG_GATEWAY_IP, {$urandom, gw});
        reg_write(REG_LOCAL_MAC, {16'($urandom), mac});
    endtask

    task automatic send_word(input acr_req_t w);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req <= w;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        sb.note_word(w);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_word(random_word());
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    initial
    begin
        logic [IP_W-1:0] far_ip;
        sb = new();
        far_ip = 32'hC0A8_0101;
        for (int i = 0; i < POOL_SIZE; i++)
            ip_pool[i] = {24'h0A_0000, 8'($urandom_range(1, 254))};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no local address yet
        send_word(arp_word(ARP_OP_REQUEST, rand48(), ip_pool[1], '0));
        send_word(arp_word(ARP_OP_REQUEST, rand48(), ip_pool[1], $urandom));
        send_word(arp_word(ARP_OP_REPLY, BCAST_MAC, ip_pool[1], '0));
        send_word(resolve_word(ip_pool[2]));
        send_word(resolve_word(BCAST_IP));
        send_word(resolve_word('0));
        send_random(80);
        drain();

        apply_setting(32'h0A00_0005, 32'hFFFF_FF00, ip_pool[0], rand48());
        send_word(arp_word(ARP_OP_REQUEST, rand48(), ip_pool[3], sb.own_ip) ^ (16'hFFFE << 176));
        send_word(arp_word(ARP_OP_REQUEST, rand48(), ip_pool[3], sb.own_ip) ^ (16'h0800 << 160));
        begin
            acr_req_t w;
            w = arp_word(ARP_OP_REQUEST, rand48(), ip_pool[3], sb.own_ip);
            w.hw_len = 8'h00;
            send_word(w);
            w = arp_word(ARP_OP_REQUEST, rand48(), ip_pool[3], sb.own_ip);
            w.proto_len = 8'hFF;
            send_word(w);
        end
        send_word(arp_word(16'd0, rand48(), ip_pool[3], sb.own_ip));
        send_word(arp_word(16'd3, rand48(), ip_pool[3], sb.own_ip));
        send_word(arp_word(16'hFFFF, rand48(), ip_pool[3], sb.own_ip));
        send_word(arp_word(ARP_OP_REQUEST, BCAST_MAC, ip_pool[3], sb.own_ip));
        send_word(arp_word(ARP_OP_REQUEST, '0, ip_pool[1], sb.own_ip));
        send_word(arp_word(ARP_OP_REPLY, rand48(), ip_pool[2], sb.own_ip));
        send_word(arp_word(ARP_OP_REQUEST, 48'hFFFF_FFFF_FFFE, ip_pool[1], ip_pool[4]));
        send_word(resolve_word(ip_pool[1]));
        send_word(resolve_word(ip_pool[5]));
        send_word(resolve_word(far_ip));
        send_word(arp_word(ARP_OP_REPLY, rand48(), ip_pool[0], sb.own_ip));
        send_word(resolve_word(far_ip));
        send_word(resolve_word(BCAST_IP));
        send_word(resolve_word('0));
        send_word(arp_word(ARP_OP_REQUEST, rand48(), '0, sb.own_ip));
        send_word(arp_word(ARP_OP_REQUEST, 48'hFFFF_FFFF_FFFE, BCAST_IP, sb.own_ip));
        send_word(arp_word(ARP_OP_REQUEST, rand48(), ip_pool[6], ip_pool[7]));
        send_word(resolve_word(sb.own_ip));
        send_random(400);
        drain();

        // host route only, no gateway: every other destination but broadcast is refused
        idle_on = 1'b0;
        apply_setting(32'hFFFF_FFFE, 32'hFFFF_FFFF, '0, '0);
        send_random(200);
        drain();

        idle_on = 1'b1;
        apply_setting(32'h0000_0001, '0, BCAST_IP, BCAST_MAC);
        send_random(200);
        drain();

        apply_setting(32'h0A00_00FE, 32'hFFFF_0000, ip_pool[3], rand48());
        rsp_hold = LONG_HOLD;
        send_random(220);
        drain();

        repeat (TABLE_ENTRIES + 20) @(posedge clk);
        sb.flush_check();
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/acr_pkg.sv
hdl/acr_cell.sv
hdl/arp_cache_responder.sv
bench/arp_cache_responder_tb.sv
